// File: rtl/accumulator_cpu_core_defines.svh
// Assertion macros for the checker file of the accumulator CPU core.
`ifndef ACCUMULATOR_CPU_CORE_DEFINES_SVH
`define ACCUMULATOR_CPU_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ACC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("accumulator core assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define ACC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("accumulator core assertion failed");

`endif

// File: rtl/acc_pkg.sv
// Types and constants of the accumulator CPU core.
package acc_pkg;

  localparam int unsigned DEF_SYSTEM_VECTOR    = 1500;
  localparam int unsigned DEF_TIMER_VECTOR     = 1000;
  localparam int unsigned DEF_SYSTEM_STACK_TOP = 2000;
  localparam int unsigned DEF_USER_STACK_TOP   = 1000;
  localparam logic [15:0] TIMER_PERIOD_RESET   = 16'd100;
  localparam logic [15:0] PEND_MAX             = 16'hFFFF;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic [1:0] MODE_USER   = 2'd0;
  localparam logic [1:0] MODE_SYSTEM = 2'd1;
  localparam logic [1:0] MODE_TIMER  = 2'd2;

  localparam logic [1:0] PUT_NONE = 2'd0;
  localparam logic       OP_START = 1'b0;
  localparam logic       OP_RESP  = 1'b1;
  localparam logic [1:0] ERR_OK   = 2'd0;

  // Opcodes.
  localparam logic [31:0] OC_LOAD_VAL  = 32'd1;
  localparam logic [31:0] OC_LOAD_ADDR = 32'd2;
  localparam logic [31:0] OC_LOAD_IND  = 32'd3;
  localparam logic [31:0] OC_LOAD_IDX  = 32'd4;
  localparam logic [31:0] OC_LOAD_IDY  = 32'd5;
  localparam logic [31:0] OC_LOAD_SPX  = 32'd6;
  localparam logic [31:0] OC_STORE     = 32'd7;
  localparam logic [31:0] OC_GET       = 32'd8;
  localparam logic [31:0] OC_PUT       = 32'd9;
  localparam logic [31:0] OC_ADD_X     = 32'd10;
  localparam logic [31:0] OC_ADD_Y     = 32'd11;
  localparam logic [31:0] OC_SUB_X     = 32'd12;
  localparam logic [31:0] OC_SUB_Y     = 32'd13;
  localparam logic [31:0] OC_COPY_TOX  = 32'd14;
  localparam logic [31:0] OC_COPY_FROMX= 32'd15;
  localparam logic [31:0] OC_COPY_TOY  = 32'd16;
  localparam logic [31:0] OC_COPY_FROMY= 32'd17;
  localparam logic [31:0] OC_COPY_TOSP = 32'd18;
  localparam logic [31:0] OC_COPY_FROMSP=32'd19;
  localparam logic [31:0] OC_JUMP      = 32'd20;
  localparam logic [31:0] OC_JUMP_EQ   = 32'd21;
  localparam logic [31:0] OC_JUMP_NE   = 32'd22;
  localparam logic [31:0] OC_CALL      = 32'd23;
  localparam logic [31:0] OC_RET       = 32'd24;
  localparam logic [31:0] OC_INC_X     = 32'd25;
  localparam logic [31:0] OC_DEC_X     = 32'd26;
  localparam logic [31:0] OC_PUSH      = 32'd27;
  localparam logic [31:0] OC_POP       = 32'd28;
  localparam logic [31:0] OC_INT       = 32'd29;
  localparam logic [31:0] OC_IRET      = 32'd30;
  localparam logic [31:0] OC_MOD       = 32'd31;
  localparam logic [31:0] OC_CALL_AC   = 32'd32;
  localparam logic [31:0] OC_END       = 32'd50;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_FETCH  = 4'd1,
    PH_OPND   = 4'd2,
    PH_SECOND = 4'd3,
    PH_THIRD  = 4'd4,
    PH_SPREAD = 4'd5,
    PH_IRET2  = 4'd6,
    PH_WACK   = 4'd7,
    PH_INT1   = 4'd8,
    PH_INT2   = 4'd9,
    PH_TINT1  = 4'd10,
    PH_TINT2  = 4'd11
  } phase_t;

  typedef enum logic [3:0] {
    ACT_NONE   = 4'b0001,
    ACT_ACCESS = 4'b0010,
    ACT_FINISH = 4'b0100,
    ACT_INT    = 4'b1000
  } act_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_STEP   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_MODFIN = 5'b01000,
    ST_OUT    = 5'b10000
  } ctl_state_t;

endpackage

// File: rtl/acc_cmd_if.sv
// Channel interfaces of the accumulator CPU core: command, request and configuration.
interface acc_cmd_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] resp_data;
  logic        [1:0]  resp_error;
  logic signed [31:0] random_value;
  modport source (output valid, op, resp_data, resp_error, random_value, input ready);
  modport sink   (input valid, op, resp_data, resp_error, random_value, output ready);
endinterface

interface acc_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  req_kind;
  logic        [1:0]  req_mode;
  logic signed [31:0] req_address;
  logic signed [31:0] req_write_data;
  logic        [1:0]  put_kind;
  logic signed [31:0] put_value;
  modport source (output valid, req_kind, req_mode, req_address, req_write_data,
                  put_kind, put_value, input ready);
  modport sink   (input valid, req_kind, req_mode, req_address, req_write_data,
                  put_kind, put_value, output ready);
endinterface

interface acc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: rtl/accumulator_cpu_core.sv
// A beat on cmd is taken in idle and latched; the step state then registers its request beat.
// Mod first runs the shared bit-serial remainder unit and registers its beat in the modfin state.
// One cmd beat is handled at a time; cmd and cfg stall until its request beat, if any, is taken.
// A cfg write with a nonzero period runs the same remainder unit to set the tick remainder.
// Reset (rst, synchronous, active high) clears the control state and CPU registers, but sets sp to the user stack top.
module accumulator_cpu_core
  import acc_pkg::*;
#(
  parameter int unsigned SYSTEM_VECTOR    = DEF_SYSTEM_VECTOR,
  parameter int unsigned TIMER_VECTOR     = DEF_TIMER_VECTOR,
  parameter int unsigned SYSTEM_STACK_TOP = DEF_SYSTEM_STACK_TOP,
  parameter int unsigned USER_STACK_TOP   = DEF_USER_STACK_TOP
) (
  input logic       clk,
  input logic       rst,
  acc_cmd_if.sink   cmd,
  acc_req_if.source req,
  acc_cfg_if.sink   cfg
);

  localparam logic [31:0] SysVec = 32'(SYSTEM_VECTOR);
  localparam logic [31:0] TmrVec = 32'(TIMER_VECTOR);
  localparam logic [31:0] SysTop = 32'(SYSTEM_STACK_TOP);
  localparam logic [31:0] UsrTop = 32'(USER_STACK_TOP);

  ctl_state_t state;

  // CPU registers
  logic [31:0] pc, ac, ix, iy, sp, ir, cnt, temp;
  logic [1:0]  mode;
  logic [15:0] pend;
  phase_t      phase;
  logic        halted;

  // timer period and instr count modulo period, kept incrementally
  logic [15:0] period;
  logic [15:0] tick_rem;

  // latched command beat
  logic        l_op;
  logic [31:0] l_data;
  logic [1:0]  l_err;
  logic [31:0] l_rnd;

  // shared remainder unit
  logic [31:0] div_rem, div_dvd, div_den;
  logic [4:0]  div_cnt;
  logic        div_for_cfg;
  logic        div_neg;
  logic [32:0] div_sh;
  logic [31:0] div_rem_next;

  assign div_sh       = {div_rem, div_dvd[31]};
  assign div_rem_next = (div_sh >= {1'b0, div_den}) ? 32'(div_sh - {1'b0, div_den})
                                                    : div_sh[31:0];

  // next-state values of one step
  logic [31:0] pc_next, ac_next, ix_next, iy_next, sp_next, ir_next, cnt_next, temp_next;
  logic [1:0]  mode_next;
  logic [15:0] pend_next, rem_next;
  phase_t      phase_next;
  logic        halted_next;
  logic        produce, need_mod;
  logic [1:0]  o_kind, o_mode, o_pk;
  logic [31:0] o_addr, o_data, o_pv;

  assign cmd.ready = (state == ST_IDLE) && !cfg.valid;
  assign cfg.ready = (state == ST_IDLE);

  always_comb begin
    act_t        act;
    logic        is_wr;
    logic [31:0] a_addr, a_data, int_ret, old_sp, mod_val;
    logic [1:0]  int_mode;
    phase_t      a_ph;
    logic        fire, hit;

    pc_next = pc; ac_next = ac; ix_next = ix; iy_next = iy; sp_next = sp;
    ir_next = ir; cnt_next = cnt; temp_next = temp; mode_next = mode;
    pend_next = pend; rem_next = tick_rem; phase_next = phase; halted_next = halted;
    produce = 1'b1; need_mod = 1'b0;
    o_kind = KIND_NONE; o_addr = '0; o_data = '0; o_pk = PUT_NONE; o_pv = '0;
    act = ACT_NONE; is_wr = 1'b0; a_addr = '0; a_data = '0; a_ph = phase;
    int_ret = '0; int_mode = MODE_USER; old_sp = '0; fire = 1'b0; hit = 1'b0;
    mod_val = div_neg ? 32'(-div_rem) : div_rem;

    if (halted) begin
      produce = 1'b1;
    end else if (l_op == OP_START) begin
      if (phase != PH_IDLE) produce = 1'b0;
      else begin
        act = ACT_ACCESS; a_addr = pc; a_ph = PH_FETCH;
      end
    end else if (phase == PH_IDLE) begin
      produce = 1'b0;
    end else if (l_err != ERR_OK) begin
      halted_next = 1'b1; phase_next = PH_IDLE; o_kind = KIND_END;
    end else if (phase == PH_FETCH) begin
      ir_next = l_data;
      case (l_data)
        OC_LOAD_VAL, OC_LOAD_ADDR, OC_LOAD_IND, OC_LOAD_IDX, OC_LOAD_IDY, OC_STORE,
        OC_PUT, OC_JUMP, OC_MOD: begin
          pc_next = pc + 32'd1; act = ACT_ACCESS; a_addr = pc_next; a_ph = PH_OPND;
        end
        OC_JUMP_EQ, OC_JUMP_NE: begin
          if ((ac == '0) == (l_data == OC_JUMP_EQ)) begin
            pc_next = pc + 32'd1; act = ACT_ACCESS; a_addr = pc_next; a_ph = PH_OPND;
          end else begin
            pc_next = pc + 32'd2; act = ACT_FINISH;
          end
        end
        OC_LOAD_SPX: begin act = ACT_ACCESS; a_addr = sp + ix; a_ph = PH_SPREAD; end
        OC_GET:        begin ac_next = l_rnd;  pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_ADD_X:      begin ac_next = ac + ix; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_ADD_Y:      begin ac_next = ac + iy; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_SUB_X:      begin ac_next = ac - ix; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_SUB_Y:      begin ac_next = ac - iy; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_TOX:   begin ix_next = ac; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_FROMX: begin ac_next = ix; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_TOY:   begin iy_next = ac; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_FROMY: begin ac_next = iy; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_TOSP:  begin sp_next = ac; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_COPY_FROMSP:begin ac_next = sp; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_INC_X: begin ix_next = ix + 32'd1; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_DEC_X: begin ix_next = ix - 32'd1; pc_next = pc + 32'd1; act = ACT_FINISH; end
        OC_CALL, OC_PUSH, OC_CALL_AC: begin
          sp_next = sp - 32'd1; act = ACT_ACCESS; is_wr = 1'b1;
          a_addr = sp_next; a_ph = PH_WACK;
          a_data = (l_data == OC_PUSH) ? ac :
                   (l_data == OC_CALL) ? pc + 32'd2 : pc + 32'd1;
        end
        OC_RET, OC_POP, OC_IRET: begin
          act = ACT_ACCESS; a_addr = sp; a_ph = PH_SPREAD; sp_next = sp + 32'd1;
        end
        OC_INT: begin
          act = ACT_INT; int_ret = pc + 32'd1; int_mode = MODE_SYSTEM; a_ph = PH_INT1;
        end
        OC_END: begin
          cnt_next = cnt + 32'd1;
          if (period != '0) begin
            hit = (cnt_next == '0) || ({1'b0, tick_rem} + 17'd1 == {1'b0, period});
            rem_next = hit ? '0 : tick_rem + 16'd1;
          end
          halted_next = 1'b1; o_kind = KIND_END; phase_next = PH_IDLE;
        end
        default: act = ACT_FINISH;
      endcase
    end else begin
      case (phase)
        PH_OPND: begin
          case (ir)
            OC_LOAD_VAL: begin ac_next = l_data; pc_next = pc + 32'd1; act = ACT_FINISH; end
            OC_LOAD_ADDR, OC_LOAD_IND: begin
              act = ACT_ACCESS; a_addr = l_data; a_ph = PH_SECOND;
            end
            OC_LOAD_IDX: begin act = ACT_ACCESS; a_addr = l_data + ix; a_ph = PH_SECOND; end
            OC_LOAD_IDY: begin act = ACT_ACCESS; a_addr = l_data + iy; a_ph = PH_SECOND; end
            OC_STORE: begin
              act = ACT_ACCESS; is_wr = 1'b1; a_addr = l_data; a_data = ac; a_ph = PH_WACK;
            end
            OC_PUT: begin
              if (l_data == 32'd1 || l_data == 32'd2) begin
                o_pk = l_data[1:0]; o_pv = ac;
              end
              pc_next = pc + 32'd1; act = ACT_FINISH;
            end
            OC_MOD: begin
              if (state != ST_MODFIN) need_mod = 1'b1;
              if (l_data != '0) ac_next = mod_val;
              pc_next = pc + 32'd1; act = ACT_FINISH;
            end
            default: begin pc_next = l_data; act = ACT_FINISH; end
          endcase
        end
        PH_SECOND: begin
          if (ir == OC_LOAD_IND) begin
            act = ACT_ACCESS; a_addr = l_data; a_ph = PH_THIRD;
          end else begin
            ac_next = l_data; pc_next = pc + 32'd1; act = ACT_FINISH;
          end
        end
        PH_THIRD: begin ac_next = l_data; pc_next = pc + 32'd1; act = ACT_FINISH; end
        PH_SPREAD: begin
          if (ir == OC_RET) begin
            pc_next = l_data; act = ACT_FINISH;
          end else if (ir == OC_IRET) begin
            pc_next = l_data; act = ACT_ACCESS; a_addr = sp; a_ph = PH_IRET2;
            sp_next = sp + 32'd1;
          end else begin
            ac_next = l_data; pc_next = pc + 32'd1; act = ACT_FINISH;
          end
        end
        PH_IRET2: begin sp_next = l_data; mode_next = MODE_USER; act = ACT_FINISH; end
        PH_WACK: begin
          if (ir == OC_CALL) begin
            pc_next = pc + 32'd1; act = ACT_ACCESS; a_addr = pc_next; a_ph = PH_OPND;
          end else if (ir == OC_CALL_AC) begin
            pc_next = ac; act = ACT_FINISH;
          end else begin
            pc_next = pc + 32'd1; act = ACT_FINISH;
          end
        end
        PH_INT1, PH_TINT1: begin
          sp_next = SysTop - 32'd2; act = ACT_ACCESS; is_wr = 1'b1;
          a_addr = sp_next; a_data = temp;
          a_ph = (phase == PH_INT1) ? PH_INT2 : PH_TINT2;
        end
        PH_INT2: begin pc_next = SysVec; act = ACT_FINISH; end
        default: begin pc_next = TmrVec; act = ACT_ACCESS; a_addr = pc_next; a_ph = PH_FETCH; end
      endcase
    end

    // timer check after every instruction
    if (act == ACT_FINISH) begin
      cnt_next = cnt + 32'd1;
      if (mode_next == MODE_USER && pend_next != '0) begin
        fire = 1'b1; pend_next = pend_next - 16'd1;
      end
      if (period != '0) begin
        hit = (cnt_next == '0) || ({1'b0, tick_rem} + 17'd1 == {1'b0, period});
        rem_next = hit ? '0 : tick_rem + 16'd1;
        if (hit) begin
          if (mode_next == MODE_USER && !fire) fire = 1'b1;
          else if (pend_next != PEND_MAX) pend_next = pend_next + 16'd1;
        end
      end
      if (fire) begin
        act = ACT_INT; int_ret = pc_next; int_mode = MODE_TIMER; a_ph = PH_TINT1;
      end else begin
        act = ACT_ACCESS; a_addr = pc_next; a_ph = PH_FETCH;
      end
    end

    // interrupt entry: push old stack pointer on the system stack
    if (act == ACT_INT) begin
      old_sp = sp_next; mode_next = int_mode; temp_next = int_ret;
      sp_next = SysTop - 32'd1;
      act = ACT_ACCESS; is_wr = 1'b1; a_addr = sp_next; a_data = old_sp;
    end

    if (act == ACT_ACCESS) begin
      o_kind = is_wr ? KIND_WRITE : KIND_READ;
      o_addr = a_addr; o_data = a_data; phase_next = a_ph;
    end

    o_mode = halted ? MODE_USER : mode_next;
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      req.valid <= 1'b0;
      period <= TIMER_PERIOD_RESET;
      tick_rem <= '0;
      pc <= '0; ac <= '0; ix <= '0; iy <= '0; sp <= UsrTop; ir <= '0;
      cnt <= '0; temp <= '0; mode <= MODE_USER; pend <= '0;
      phase <= PH_IDLE; halted <= 1'b0;
      div_cnt <= '0; div_for_cfg <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (cfg.valid) begin
            // hold the tick remainder consistent with the new period
            period <= cfg.data;
            if (cfg.data != '0) begin
              div_rem <= '0; div_dvd <= cnt; div_den <= {16'd0, cfg.data};
              div_cnt <= '0; div_for_cfg <= 1'b1; div_neg <= 1'b0;
              state <= ST_DIV;
            end
          end else if (cmd.valid) begin
            l_op <= cmd.op; l_data <= cmd.resp_data; l_err <= cmd.resp_error;
            l_rnd <= cmd.random_value;
            state <= ST_STEP;
          end
        end
        ST_DIV: begin
          div_rem <= div_rem_next;
          div_dvd <= {div_dvd[30:0], 1'b0};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            if (div_for_cfg) begin
              tick_rem <= div_rem_next[15:0];
              state <= ST_IDLE;
            end else begin
              state <= ST_MODFIN;
            end
          end
        end
        ST_STEP, ST_MODFIN: begin
          if (need_mod) begin
            // start the remainder on magnitudes; sign follows the dividend
            div_rem <= '0;
            div_dvd <= ac[31] ? 32'(-ac) : ac;
            div_den <= l_data[31] ? 32'(-l_data) : l_data;
            div_neg <= ac[31];
            div_cnt <= '0; div_for_cfg <= 1'b0;
            state <= ST_DIV;
          end else begin
            pc <= pc_next; ac <= ac_next; ix <= ix_next; iy <= iy_next; sp <= sp_next;
            ir <= ir_next; cnt <= cnt_next; temp <= temp_next; mode <= mode_next;
            pend <= pend_next; tick_rem <= rem_next; phase <= phase_next;
            halted <= halted_next;
            if (produce) begin
              req.valid <= 1'b1;
              req.req_kind <= o_kind; req.req_mode <= o_mode;
              req.req_address <= o_addr; req.req_write_data <= o_data;
              req.put_kind <= o_pk; req.put_value <= o_pv;
              state <= ST_OUT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_OUT: begin
          if (req.ready) begin
            req.valid <= 1'b0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/acc_chk.sv
// Port-level checker for the accumulator CPU core, bound to the core module.
`include "accumulator_cpu_core_defines.svh"
module acc_chk
  import acc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        cfg_ready,
  input logic        req_valid,
  input logic        req_ready,
  input logic [1:0]  req_kind,
  input logic [1:0]  req_mode,
  input logic [31:0] req_address,
  input logic [31:0] req_write_data,
  input logic [1:0]  put_kind
);

  `ACC_ASSERT_NEXT(a_req_hold, req_valid && !req_ready, req_valid)
  `ACC_ASSERT_NOW(a_no_take_while_pending, req_valid, !cmd_ready && !cfg_ready)
  `ACC_ASSERT_NOW(a_halt_clean, req_valid && req_kind == KIND_NONE,
                  req_mode == MODE_USER && req_address == '0 && put_kind == PUT_NONE)
  `ACC_ASSERT_NOW(a_end_clean, req_valid && req_kind == KIND_END,
                  req_address == '0 && req_write_data == '0 && put_kind == PUT_NONE)

endmodule

bind accumulator_cpu_core acc_chk u_acc_chk (
  .clk            (clk),
  .rst            (rst),
  .cmd_ready      (cmd.ready),
  .cfg_ready      (cfg.ready),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .req_kind       (req.req_kind),
  .req_mode       (req.req_mode),
  .req_address    (req.req_address),
  .req_write_data (req.req_write_data),
  .put_kind       (req.put_kind)
);
